/* hdl/rmj_pkg.sv */
// Shared constants, types and helpers for the radar measurement Jacobian.
package rmj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                 // field width
    localparam int MW        = 2 * DW;             // squared-range / product width
    localparam int QW        = DW + FRAC_BITS;     // divider quotient width
    localparam int NDIV      = 5;                  // divider lanes sharing one divisor
    localparam int SQW       = 2 * FRAC_BITS + 2;  // square-root operand width
    localparam int SQ_STEPS  = SQW / 2;
    localparam int RW        = FRAC_BITS + 1;      // root width
    localparam int NSQ       = 2;
    localparam int PW        = QW + RW;            // rate-row product width
    localparam int THR_W     = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);
    localparam logic [DW-1:0]    NEG_CAP   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]    POS_CAP   = {1'b0, {(DW-1){1'b1}}};

    // divider lanes
    localparam int LANE_RX = 0;
    localparam int LANE_RY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;
    localparam int LANE_H  = 4;

    // square-root lanes
    localparam int SQ_X = 0;
    localparam int SQ_Y = 1;

    typedef struct packed {
        logic deg;
        logic ovf;
        logic px_neg;
        logic py_neg;
        logic py_pos;
        logic c_neg;
    } side_t;

    typedef struct packed {
        logic [DW-1:0] bx;
        logic [DW-1:0] by;
        logic [QW-1:0] h;
        side_t         side;
    } sq_tag_t;

    // sign-magnitude to two's complement with saturation
    function automatic logic [DW-1:0] pack_q(input logic neg, input logic [DW-1:0] mag);
        logic [DW-1:0] m;
        if (neg) begin
            m = (mag > NEG_CAP) ? NEG_CAP : mag;
            pack_q = DW'(0) - m;
        end
        else begin
            pack_q = (mag > POS_CAP) ? POS_CAP : mag;
        end
    endfunction

endpackage

/* hdl/rmj_if.sv */
// Handshake channels for state words in and Jacobian words out.
interface rmj_state_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                    output ready);
endinterface

interface rmj_jac_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] d_range_d_px;
    logic signed [31:0] d_range_d_py;
    logic signed [31:0] d_bearing_d_px;
    logic signed [31:0] d_bearing_d_py;
    logic signed [31:0] d_rate_d_px;
    logic signed [31:0] d_rate_d_py;
    logic               degenerate;

    modport source (output valid, output d_range_d_px, output d_range_d_py,
                    output d_bearing_d_px, output d_bearing_d_py,
                    output d_rate_d_px, output d_rate_d_py, output degenerate,
                    input ready);
    modport sink   (input valid, input d_range_d_px, input d_range_d_py,
                    input d_bearing_d_px, input d_bearing_d_py,
                    input d_rate_d_px, input d_rate_d_py, input degenerate,
                    output ready);
endinterface

/* hdl/radar_measurement_jacobian_top.sv */
// Radar measurement Jacobian top level: squares, shared divider, square roots, rate row.
// Pipeline: an accepted state word passes 3 prep stages, 48 divider stages, 17 square-root stages,
// and the multiply and output stages on its way to its Jacobian word.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset clears all valid bits and loads thr_reg with 7; data registers are not reset.
module radar_measurement_jacobian_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rmj_pkg::THR_W-1:0]   cfg_wr_data,
    rmj_state_if.sink                   state,
    rmj_jac_if.source                   jac
);
    import rmj_pkg::*;

    logic             en;
    logic [THR_W-1:0] thr_reg;

    // stage A: magnitudes and products
    logic [DW-1:0]        ax_c, ay_c;
    logic [MW-1:0]        ax2_c, ay2_c;
    logic signed [MW-1:0] t1_c, t2_c;
    logic                 a_v_reg;
    logic [DW-1:0]        a_ax_reg, a_ay_reg;
    logic [MW-1:0]        a_ax2_reg, a_ay2_reg;
    logic signed [MW-1:0] a_t1_reg, a_t2_reg;
    logic                 a_px_neg_reg, a_py_neg_reg, a_py_pos_reg;

    // stage B: squared range and cross term
    logic [MW:0]   d1_c, d2_c;
    logic          b_v_reg;
    logic [MW-1:0] b_s_reg, b_cmag_reg, b_ax2_reg, b_ay2_reg;
    logic [DW-1:0] b_ax_reg, b_ay_reg;
    logic          b_cneg_reg, b_px_neg_reg, b_py_neg_reg, b_py_pos_reg;

    // stage C: divider operands
    logic                    deg_c, ovf_c;
    logic [NDIV-1:0][MW-1:0] rem0_c;
    logic [NDIV-1:0][QW-1:0] low_c;
    logic                    c_v_reg;
    logic [MW-1:0]           c_s_reg;
    logic [NDIV-1:0][MW-1:0] c_rem0_reg;
    logic [NDIV-1:0][QW-1:0] c_low_reg;
    side_t                   c_side_reg;

    logic                    dv_valid;
    logic [NDIV-1:0][QW-1:0] dv_q;
    side_t                   dv_side;

    logic [NSQ-1:0][SQW-1:0] sq_x;
    sq_tag_t                 sq_in_tag;
    logic                    sq_valid;
    logic [NSQ-1:0][RW-1:0]  sq_root;
    sq_tag_t                 sq_tag;

    // stage M: rate-row products
    logic          m_v_reg;
    logic [PW-1:0] m_tx_reg, m_ty_reg;
    logic [RW-1:0] m_rx_reg, m_ry_reg;
    logic [DW-1:0] m_bx_reg, m_by_reg;
    side_t         m_side_reg;

    // stage O: output word
    logic [PW-1:0] tx_s, ty_s;
    logic [DW-1:0] tx_c, ty_c;
    logic          o_v_reg;
    logic [DW-1:0] o_rx_reg, o_ry_reg, o_bx_reg, o_by_reg, o_tx_reg, o_ty_reg;
    logic          o_deg_reg;

    assign en          = !o_v_reg || jac.ready;
    assign state.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage A
    assign ax_c  = state.pos_x[DW-1] ? DW'(-state.pos_x) : DW'(state.pos_x);
    assign ay_c  = state.pos_y[DW-1] ? DW'(-state.pos_y) : DW'(state.pos_y);
    assign ax2_c = ax_c * ax_c;
    assign ay2_c = ay_c * ay_c;
    assign t1_c  = state.vel_x * state.pos_y;
    assign t2_c  = state.vel_y * state.pos_x;

    // ---------------- stage B
    assign d1_c = {a_t1_reg[MW-1], a_t1_reg} - {a_t2_reg[MW-1], a_t2_reg};
    assign d2_c = {a_t2_reg[MW-1], a_t2_reg} - {a_t1_reg[MW-1], a_t1_reg};

    // ---------------- stage C
    assign deg_c = (b_s_reg == '0) || (b_s_reg < (MW'(thr_reg) << FRAC_BITS));
    // quotient would not fit the divider: rate row saturates
    assign ovf_c = (b_cmag_reg >> (QW - FRAC_BITS)) >= b_s_reg;

    assign rem0_c[LANE_RX] = b_ax2_reg >> (QW - 2 * FRAC_BITS);
    assign low_c[LANE_RX]  = QW'(b_ax2_reg << (2 * FRAC_BITS));
    assign rem0_c[LANE_RY] = b_ay2_reg >> (QW - 2 * FRAC_BITS);
    assign low_c[LANE_RY]  = QW'(b_ay2_reg << (2 * FRAC_BITS));
    assign rem0_c[LANE_BX] = MW'(b_ay_reg) >> (QW - 2 * FRAC_BITS);
    assign low_c[LANE_BX]  = QW'(MW'(b_ay_reg) << (2 * FRAC_BITS));
    assign rem0_c[LANE_BY] = MW'(b_ax_reg) >> (QW - 2 * FRAC_BITS);
    assign low_c[LANE_BY]  = QW'(MW'(b_ax_reg) << (2 * FRAC_BITS));
    assign rem0_c[LANE_H]  = b_cmag_reg >> (QW - FRAC_BITS);
    assign low_c[LANE_H]   = QW'(b_cmag_reg << FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= state.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            m_v_reg <= sq_valid;
            o_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ax_reg     <= ax_c;
            a_ay_reg     <= ay_c;
            a_ax2_reg    <= ax2_c;
            a_ay2_reg    <= ay2_c;
            a_t1_reg     <= t1_c;
            a_t2_reg     <= t2_c;
            a_px_neg_reg <= state.pos_x[DW-1];
            a_py_neg_reg <= state.pos_y[DW-1];
            a_py_pos_reg <= !state.pos_y[DW-1] && (state.pos_y != '0);

            b_s_reg      <= a_ax2_reg + a_ay2_reg;
            b_cneg_reg   <= d1_c[MW];
            b_cmag_reg   <= d1_c[MW] ? d2_c[MW-1:0] : d1_c[MW-1:0];
            b_ax2_reg    <= a_ax2_reg;
            b_ay2_reg    <= a_ay2_reg;
            b_ax_reg     <= a_ax_reg;
            b_ay_reg     <= a_ay_reg;
            b_px_neg_reg <= a_px_neg_reg;
            b_py_neg_reg <= a_py_neg_reg;
            b_py_pos_reg <= a_py_pos_reg;

            c_s_reg           <= b_s_reg;
            c_rem0_reg        <= rem0_c;
            c_low_reg         <= low_c;
            c_side_reg.deg    <= deg_c;
            c_side_reg.ovf    <= ovf_c;
            c_side_reg.px_neg <= b_px_neg_reg;
            c_side_reg.py_neg <= b_py_neg_reg;
            c_side_reg.py_pos <= b_py_pos_reg;
            c_side_reg.c_neg  <= b_cneg_reg;
        end
    end

    rmj_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_v_reg),
        .d         (c_s_reg),
        .rem0      (c_rem0_reg),
        .low       (c_low_reg),
        .in_side   (c_side_reg),
        .out_valid (dv_valid),
        .q         (dv_q),
        .out_side  (dv_side)
    );

    assign sq_x[SQ_X]     = dv_q[LANE_RX][SQW-1:0];
    assign sq_x[SQ_Y]     = dv_q[LANE_RY][SQW-1:0];
    assign sq_in_tag.bx   = (dv_q[LANE_BX] > QW'(NEG_CAP)) ? NEG_CAP : dv_q[LANE_BX][DW-1:0];
    assign sq_in_tag.by   = (dv_q[LANE_BY] > QW'(NEG_CAP)) ? NEG_CAP : dv_q[LANE_BY][DW-1:0];
    assign sq_in_tag.h    = dv_side.ovf ? '1 : dv_q[LANE_H];
    assign sq_in_tag.side = dv_side;

    rmj_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .x         (sq_x),
        .in_tag    (sq_in_tag),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // ---------------- stage O
    assign tx_s = m_tx_reg >> FRAC_BITS;
    assign ty_s = m_ty_reg >> FRAC_BITS;
    assign tx_c = (tx_s > PW'(NEG_CAP)) ? NEG_CAP : tx_s[DW-1:0];
    assign ty_c = (ty_s > PW'(NEG_CAP)) ? NEG_CAP : ty_s[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tx_reg   <= sq_tag.h * sq_root[SQ_Y];
            m_ty_reg   <= sq_tag.h * sq_root[SQ_X];
            m_rx_reg   <= sq_root[SQ_X];
            m_ry_reg   <= sq_root[SQ_Y];
            m_bx_reg   <= sq_tag.bx;
            m_by_reg   <= sq_tag.by;
            m_side_reg <= sq_tag.side;

            o_deg_reg <= m_side_reg.deg;
            if (m_side_reg.deg)
            begin
                o_rx_reg <= '0;
                o_ry_reg <= '0;
                o_bx_reg <= '0;
                o_by_reg <= '0;
                o_tx_reg <= '0;
                o_ty_reg <= '0;
            end
            else
            begin
                o_rx_reg <= pack_q(m_side_reg.px_neg, DW'(m_rx_reg));
                o_ry_reg <= pack_q(m_side_reg.py_neg, DW'(m_ry_reg));
                o_bx_reg <= pack_q(m_side_reg.py_pos, m_bx_reg);
                o_by_reg <= pack_q(m_side_reg.px_neg, m_by_reg);
                o_tx_reg <= pack_q(m_side_reg.py_neg ^ m_side_reg.c_neg, tx_c);
                o_ty_reg <= pack_q(!(m_side_reg.px_neg ^ m_side_reg.c_neg), ty_c);
            end
        end
    end

    assign jac.valid          = o_v_reg;
    assign jac.d_range_d_px   = o_rx_reg;
    assign jac.d_range_d_py   = o_ry_reg;
    assign jac.d_bearing_d_px = o_bx_reg;
    assign jac.d_bearing_d_py = o_by_reg;
    assign jac.d_rate_d_px    = o_tx_reg;
    assign jac.d_rate_d_py    = o_ty_reg;
    assign jac.degenerate     = o_deg_reg;

endmodule

/* hdl/rmj_div.sv */
// Pipelined restoring divider: several lanes share one divisor, one quotient bit per stage.
module rmj_div (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic [rmj_pkg::MW-1:0]                     d,
    input  logic [rmj_pkg::NDIV-1:0][rmj_pkg::MW-1:0]  rem0,
    input  logic [rmj_pkg::NDIV-1:0][rmj_pkg::QW-1:0]  low,
    input  rmj_pkg::side_t                             in_side,
    output logic                                       out_valid,
    output logic [rmj_pkg::NDIV-1:0][rmj_pkg::QW-1:0]  q,
    output rmj_pkg::side_t                             out_side
);
    import rmj_pkg::*;

    // rem0 must already be below d; low holds the dividend bits still to shift in
    logic [QW-1:0]                v_src;
    logic [QW-1:0]                v_reg;
    logic [MW-1:0]                d_src    [QW];
    logic [MW-1:0]                d_reg    [QW];
    logic [NDIV-1:0][MW-1:0]      rem_src  [QW];
    logic [NDIV-1:0][MW-1:0]      rem_next [QW];
    logic [NDIV-1:0][MW-1:0]      rem_reg  [QW];
    logic [NDIV-1:0][QW-1:0]      low_src  [QW];
    logic [NDIV-1:0][QW-1:0]      low_next [QW];
    logic [NDIV-1:0][QW-1:0]      low_reg  [QW];
    logic [NDIV-1:0][QW-1:0]      q_src    [QW];
    logic [NDIV-1:0][QW-1:0]      q_next   [QW];
    logic [NDIV-1:0][QW-1:0]      q_reg    [QW];
    side_t                        side_src [QW];
    side_t                        side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign v_src[k]    = in_valid;
            assign d_src[k]    = d;
            assign rem_src[k]  = rem0;
            assign low_src[k]  = low;
            assign q_src[k]    = '0;
            assign side_src[k] = in_side;
        end
        else begin : g_rest
            assign v_src[k]    = v_reg[k-1];
            assign d_src[k]    = d_reg[k-1];
            assign rem_src[k]  = rem_reg[k-1];
            assign low_src[k]  = low_reg[k-1];
            assign q_src[k]    = q_reg[k-1];
            assign side_src[k] = side_reg[k-1];
        end

        for (genvar l = 0; l < NDIV; l++) begin : g_lane
            logic [MW:0] trial;
            logic        take;

            assign trial = {rem_src[k][l], low_src[k][l][QW-1]};
            assign take  = trial >= {1'b0, d_src[k]};
            assign rem_next[k][l] = take ? MW'(trial - {1'b0, d_src[k]}) : trial[MW-1:0];
            assign q_next[k][l]   = {q_src[k][l][QW-2:0], take};
            assign low_next[k][l] = {low_src[k][l][QW-2:0], 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= d_src[k];
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                q_reg[k]    <= q_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign q         = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

/* hdl/rmj_sqrt.sv */
// Pipelined integer square root, two lanes, one result bit per stage.
module rmj_sqrt (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic [rmj_pkg::NSQ-1:0][rmj_pkg::SQW-1:0]  x,
    input  rmj_pkg::sq_tag_t                           in_tag,
    output logic                                       out_valid,
    output logic [rmj_pkg::NSQ-1:0][rmj_pkg::RW-1:0]   root,
    output rmj_pkg::sq_tag_t                           out_tag
);
    import rmj_pkg::*;

    logic [SQ_STEPS-1:0]      v_src;
    logic [SQ_STEPS-1:0]      v_reg;
    logic [NSQ-1:0][SQW-1:0]  x_src    [SQ_STEPS];
    logic [NSQ-1:0][SQW-1:0]  x_next   [SQ_STEPS];
    logic [NSQ-1:0][SQW-1:0]  x_reg    [SQ_STEPS];
    logic [NSQ-1:0][SQW-1:0]  r_src    [SQ_STEPS];
    logic [NSQ-1:0][SQW-1:0]  r_next   [SQ_STEPS];
    logic [NSQ-1:0][SQW-1:0]  r_reg    [SQ_STEPS];
    sq_tag_t                  tag_src  [SQ_STEPS];
    sq_tag_t                  tag_reg  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);

        if (k == 0) begin : g_first
            assign v_src[k]   = in_valid;
            assign x_src[k]   = x;
            assign r_src[k]   = '0;
            assign tag_src[k] = in_tag;
        end
        else begin : g_rest
            assign v_src[k]   = v_reg[k-1];
            assign x_src[k]   = x_reg[k-1];
            assign r_src[k]   = r_reg[k-1];
            assign tag_src[k] = tag_reg[k-1];
        end

        for (genvar l = 0; l < NSQ; l++) begin : g_lane
            logic [SQW:0] trial;
            logic         take;

            assign trial = {1'b0, r_src[k][l]} + {1'b0, BIT};
            assign take  = {1'b0, x_src[k][l]} >= trial;
            assign x_next[k][l] = take ? SQW'({1'b0, x_src[k][l]} - trial) : x_src[k][l];
            assign r_next[k][l] = take ? (r_src[k][l] >> 1) + BIT : r_src[k][l] >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_next[k];
                r_reg[k]   <= r_next[k];
                tag_reg[k] <= tag_src[k];
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS-1];
    for (genvar l = 0; l < NSQ; l++) begin : g_out
        assign root[l] = r_reg[SQ_STEPS-1][l][RW-1:0];
    end
    assign out_tag = tag_reg[SQ_STEPS-1];

endmodule
